>>> sv/assert_macros.svh
// Assertion helper macros shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // default geometry of the screen store
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // field widths
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 7;
    localparam int COLUMNS_W   = 8;
    localparam int ROWS_W      = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // register reset values
    localparam int COLUMNS_RESET = 80;
    localparam int ROWS_RESET    = 25;

    // register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7E;

    localparam int TAB_STOP = 4;
    localparam int TAB_MASK = TAB_STOP - 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT  = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_SET  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_CLR,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input word
        logic exec;      // carry out the operation
        logic rd_done;   // store read data as result
        logic scr_rd;    // scroll: read the cell one row below
        logic scr_wr;    // scroll: write it one row up
        logic scr_clr;   // scroll: clear a cell of the last row
        logic clr_wr;    // power-up clear of the store
        logic load_out;  // load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic func_read;
        logic scroll;
        logic multi_row;
        logic row_end;
        logic copy_done;
        logic clr_last;
    } stat_t;

endpackage

>>> sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.func_read) begin
                    state_next = ST_RD_WAIT;
                end else if (stat.scroll) begin
                    state_next = stat.multi_row ? ST_SCR_RD : ST_SCR_CLR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_SCR_RD:  state_next = ST_SCR_WR;
            ST_SCR_WR: begin
                if (stat.row_end && stat.copy_done) state_next = ST_SCR_CLR;
                else state_next = ST_SCR_RD;
            end
            ST_SCR_CLR: begin
                if (stat.row_end) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.rd_done  = (state_reg == ST_RD_WAIT);
        cmd.scr_rd   = (state_reg == ST_SCR_RD);
        cmd.scr_wr   = (state_reg == ST_SCR_WR);
        cmd.scr_clr  = (state_reg == ST_SCR_CLR);
        cmd.clr_wr   = (state_reg == ST_CLEAR);
        cmd.load_out = (state_reg == ST_DONE) && slot_free;
        s_ready      = (state_reg == ST_IDLE);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == ST_EXEC)
    `ASSERT_IMPL(a_load_slot_free, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready)
    `ASSERT_NEXT(a_clear_end, aclk, aresetn, state_reg == ST_CLEAR && stat.clr_last, state_reg == ST_IDLE)

endmodule

>>> sv/tcw_datapath.sv
// Datapath of the text console writer: screen store, cursor, registers, result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [FUNC_W-1:0]      in_func,
    input  logic [CHAR_W-1:0]      in_char,
    input  logic [ROW_FIELD_W-1:0] in_row,
    input  logic [COL_FIELD_W-1:0] in_col,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [COLUMNS_W-1:0]   cfg_data,
    output logic [CHAR_W-1:0]      out_cell,
    output logic [COL_FIELD_W-1:0] out_col,
    output logic [ROW_FIELD_W-1:0] out_row
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int XW     = (NC_W > COLUMNS_W) ? NC_W : COLUMNS_W;
    localparam int YW     = (NR_W > ROWS_W) ? NR_W : ROWS_W;
    localparam int XW1    = XW + 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [XW-1:0] NC_RST =
        XW'((COLUMNS_RESET > MAX_COLS) ? MAX_COLS : COLUMNS_RESET);
    localparam logic [YW-1:0] NR_RST =
        YW'((ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET);

    // cells are laid out as {row, col}
    logic [CHAR_W-1:0] screen_mem [DEPTH];

    logic [XW-1:0]          nc_reg;
    logic [YW-1:0]          nr_reg;
    logic [COL_W-1:0]       cx_reg;
    logic [ROW_W-1:0]       cy_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [ROW_FIELD_W-1:0] row_reg;
    logic [COL_FIELD_W-1:0] col_reg;
    logic                   in_range_reg;
    logic [COL_W-1:0]       sc_reg;
    logic [ROW_W-1:0]       sr_reg;
    logic [CHAR_W-1:0]      res_cell_reg;
    logic [CHAR_W-1:0]      rdata_reg;
    logic [CHAR_W-1:0]      out_cell_reg;
    logic [COL_FIELD_W-1:0] out_col_reg;
    logic [ROW_FIELD_W-1:0] out_row_reg;

    logic [XW-1:0]     col_x, cx_x, set_x, nc_m1, cfg_nc, cfg_nc_m1, cfg_cols;
    logic [YW-1:0]     row_y, cy_y, set_y, nr_m1, cfg_nr, cfg_nr_m1, cfg_rows;
    logic [XW1-1:0]    nx, tab_sum;
    logic [YW-1:0]     ny;
    logic              adv, put_we, put_scroll, in_range, row_end;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CHAR_W-1:0] wdata;
    logic [ROW_W-1:0]  sr_p1;

    assign col_x = XW'(col_reg);
    assign row_y = YW'(row_reg);
    assign cx_x  = XW'(cx_reg);
    assign cy_y  = YW'(cy_reg);
    assign nc_m1 = nc_reg - XW'(1);
    assign nr_m1 = nr_reg - YW'(1);
    assign sr_p1 = sr_reg + ROW_W'(1);

    assign set_x    = (col_x < nc_reg) ? col_x : nc_m1;
    assign set_y    = (row_y < nr_reg) ? row_y : nr_m1;
    assign in_range = (row_y < nr_reg) && (col_x < nc_reg);

    // effective register values: zero means one, too large means the maximum
    assign cfg_cols = XW'(cfg_data);
    assign cfg_rows = YW'(cfg_data[ROWS_W-1:0]);
    assign cfg_nc   = (cfg_cols == '0) ? XW'(1) :
                      (cfg_cols > XW'(MAX_COLS)) ? XW'(MAX_COLS) : cfg_cols;
    assign cfg_nr   = (cfg_rows == '0) ? YW'(1) :
                      (cfg_rows > YW'(MAX_ROWS)) ? YW'(MAX_ROWS) : cfg_rows;
    assign cfg_nc_m1 = cfg_nc - XW'(1);
    assign cfg_nr_m1 = cfg_nr - YW'(1);

    // cursor movement of a put
    always_comb begin
        put_we  = 1'b0;
        adv     = 1'b0;
        nx      = XW1'(cx_reg);
        tab_sum = XW1'(cx_reg) + XW1'(TAB_STOP);
        case (char_reg)
            CHAR_TAB: nx = tab_sum & ~XW1'(TAB_MASK);
            CHAR_LF: begin
                nx  = '0;
                adv = 1'b1;
            end
            CHAR_CR: nx = '0;
            CHAR_BS: begin
                if (cx_reg != '0) nx = XW1'(cx_reg) - XW1'(1);
            end
            default: begin
                if (char_reg inside {[CHAR_SPACE:CHAR_TILDE]}) begin
                    put_we = 1'b1;
                    nx     = XW1'(cx_reg) + XW1'(1);
                end
            end
        endcase
        if (nx >= XW1'(nc_reg)) begin
            nx  = '0;
            adv = 1'b1;
        end
        ny         = cy_y + YW'(adv);
        put_scroll = (ny >= nr_reg);
        if (put_scroll) ny = nr_m1;
    end

    assign row_end = (XW'(sc_reg) + XW'(1)) == nc_reg;

    always_comb begin
        stat           = '0;
        stat.func_read = (func_reg == FUNC_READ);
        stat.scroll    = (func_reg == FUNC_PUT) && put_scroll;
        stat.multi_row = (nr_reg != YW'(1));
        stat.row_end   = row_end;
        stat.copy_done = (YW'(sr_reg) + YW'(2)) == nr_reg;
        stat.clr_last  = &clr_addr_reg;
    end

    // store write port
    always_comb begin
        mem_we = 1'b0;
        waddr  = {cy_reg, cx_reg};
        wdata  = char_reg;
        if (cmd.clr_wr) begin
            mem_we = 1'b1;
            waddr  = clr_addr_reg;
            wdata  = '0;
        end else if (cmd.exec && func_reg == FUNC_PUT && put_we) begin
            mem_we = 1'b1;
        end else if (cmd.scr_wr) begin
            mem_we = 1'b1;
            waddr  = {sr_reg, sc_reg};
            wdata  = rdata_reg;
        end else if (cmd.scr_clr) begin
            mem_we = 1'b1;
            waddr  = {nr_m1[ROW_W-1:0], sc_reg};
            wdata  = '0;
        end
    end

    assign raddr = cmd.scr_rd ? {sr_p1, sc_reg} : {row_y[ROW_W-1:0], col_x[COL_W-1:0]};

    always_ff @(posedge aclk) begin
        if (mem_we) screen_mem[waddr] <= wdata;
        rdata_reg <= screen_mem[raddr];
    end

    // cursor, geometry and clear counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg       <= NC_RST;
            nr_reg       <= NR_RST;
            cx_reg       <= '0;
            cy_reg       <= '0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.clr_wr) clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cmd.exec) begin
                case (func_reg)
                    FUNC_PUT: begin
                        cx_reg <= nx[COL_W-1:0];
                        cy_reg <= ny[ROW_W-1:0];
                    end
                    FUNC_SET: begin
                        cx_reg <= set_x[COL_W-1:0];
                        cy_reg <= set_y[ROW_W-1:0];
                    end
                    default: ;
                endcase
            end else if (cfg_we) begin
                if (cfg_index == REG_COLUMNS) begin
                    nc_reg <= cfg_nc;
                    if (cx_x >= cfg_nc) cx_reg <= cfg_nc_m1[COL_W-1:0];
                end else begin
                    nr_reg <= cfg_nr;
                    if (cy_y >= cfg_nr) cy_reg <= cfg_nr_m1[ROW_W-1:0];
                end
            end
        end
    end

    // item fields, scroll walk and result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= in_func;
            char_reg <= in_char;
            row_reg  <= in_row;
            col_reg  <= in_col;
        end
        if (cmd.exec) begin
            in_range_reg <= in_range;
            res_cell_reg <= '0;
            sc_reg       <= '0;
            sr_reg       <= '0;
        end
        if (cmd.rd_done) res_cell_reg <= in_range_reg ? rdata_reg : '0;
        if (cmd.scr_wr || cmd.scr_clr) begin
            if (row_end) begin
                sc_reg <= '0;
                sr_reg <= sr_p1;
            end else begin
                sc_reg <= sc_reg + COL_W'(1);
            end
        end
        if (cmd.load_out) begin
            out_cell_reg <= res_cell_reg;
            out_col_reg  <= cx_x[COL_FIELD_W-1:0];
            out_row_reg  <= cy_y[ROW_FIELD_W-1:0];
        end
    end

    assign out_cell = out_cell_reg;
    assign out_col  = out_col_reg;
    assign out_row  = out_row_reg;

    `ASSERT_IMPL(a_cx_in_area, aclk, aresetn, 1'b1, cx_x < nc_reg)
    `ASSERT_IMPL(a_cy_in_area, aclk, aresetn, 1'b1, cy_y < nr_reg)
    `ASSERT_IMPL(a_scroll_src_in_area, aclk, aresetn, cmd.scr_wr, (YW'(sr_reg) + YW'(1)) < nr_reg)

endmodule

>>> sv/text_console_writer_unit.sv
// Top level of the text console writer.
`timescale 1ns / 1ps

// Character engine of a text console: a screen store of character codes and a cursor.
// Input words (s_axis) carry an operation in tuser: put character, read cell or set
// cursor. Each input word gives exactly one output word (m_axis) with the read cell
// (zero unless a read inside the area in use) and the cursor after the operation.
// The cfg channel writes the columns (index 0) and rows (index 1) registers; it is
// always ready and is meant to be written only while no operation is in flight.
// A put, set cursor or the unused code goes from the execute state to the done state;
// a read passes a read-wait state between them (registered store read). The done state
// loads the result register, and the next word is taken back in idle. A put that scrolls
// walks the store one cell at a time over its single read and single write port, reading
// and writing each cell of the rows moved up, then clearing each cell of the last row.
// After reset the store is cleared one cell a cycle, all 2^(clog2(MAX_COLS) +
// clog2(MAX_ROWS)) cells, 8192 with default sizes, with s_axis_tready low.
// The result register holds while m_axis_tready is low; one more input word can be
// taken and worked on meanwhile, and it waits for the slot before completing.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // char_code[7:0], row[13:8], col[20:14]
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // func[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // cell_char[7:0], cursor_col[14:8],
                                                 // cursor_row[20:15]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [COLUMNS_W-1:0] cfg_data
);

    localparam int OUT_USED_W = CHAR_W + COL_FIELD_W + ROW_FIELD_W;

    cmd_t                   cmd;
    stat_t                  stat;
    logic [CHAR_W-1:0]      out_cell;
    logic [COL_FIELD_W-1:0] out_col;
    logic [ROW_FIELD_W-1:0] out_row;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcw_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_axis_tuser),
        .in_char   (s_axis_tdata[CHAR_W-1:0]),
        .in_row    (s_axis_tdata[CHAR_W +: ROW_FIELD_W]),
        .in_col    (s_axis_tdata[CHAR_W + ROW_FIELD_W +: COL_FIELD_W]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_cell  (out_cell),
        .out_col   (out_col),
        .out_row   (out_row)
    );

    assign m_axis_tdata = {{(M_TDATA_W - OUT_USED_W){1'b0}}, out_row, out_col, out_cell};

endmodule

>>> dv/tb_text_console_writer_unit.sv
// Testbench of the text console writer: shadow screen and cursor, random streams, checks.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 100_000_000;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned REPORT_CAP = 40;

    typedef struct packed {
        logic [CHAR_W-1:0]      cell_char;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [ROW_FIELD_W-1:0] cursor_row;
    } console_result_t;

    // Shadow of the screen store and cursor; queues the results each accepted word must give.
    class console_tracker;
        logic [CHAR_W-1:0] screen [MAX_COLS_DEF*MAX_ROWS_DEF];
        int unsigned cur_x, cur_y, cols_reg, rows_reg;
        console_result_t pending_results [$];
        int unsigned err_count;

        function new();
            foreach (screen[i]) screen[i] = '0;
            cur_x = 0;
            cur_y = 0;
            cols_reg = COLUMNS_RESET;
            rows_reg = ROWS_RESET;
            err_count = 0;
        endfunction

        function int unsigned used_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
            return cols_reg;
        endfunction

        function int unsigned used_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
            return rows_reg;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void clamp_cursor();
            if (cur_x >= used_cols()) cur_x = used_cols() - 1;
            if (cur_y >= used_rows()) cur_y = used_rows() - 1;
        endfunction

        function void apply_reg(logic idx, logic [COLUMNS_W-1:0] data);
            if (idx == REG_COLUMNS) cols_reg = 32'(data);
            else rows_reg = 32'(data[ROWS_W-1:0]);
            clamp_cursor();
        endfunction

        function void scroll_up(int unsigned nc, int unsigned nr);
            for (int unsigned r = 0; r + 1 < nr; r++)
                for (int unsigned c = 0; c < nc; c++)
                    screen[r*MAX_COLS_DEF + c] = screen[(r+1)*MAX_COLS_DEF + c];
            for (int unsigned c = 0; c < nc; c++)
                screen[(nr-1)*MAX_COLS_DEF + c] = '0;
        endfunction

        function void put_char(logic [CHAR_W-1:0] ch);
            int unsigned nc, nr;
            nc = used_cols();
            nr = used_rows();
            clamp_cursor();
            if (ch >= CHAR_SPACE && ch <= CHAR_TILDE) begin
                screen[cur_y*MAX_COLS_DEF + cur_x] = ch;
                cur_x++;
            end else if (ch == CHAR_TAB) begin
                cur_x = (cur_x + TAB_STOP) & ~TAB_MASK;
            end else if (ch == CHAR_LF) begin
                cur_x = 0;
                cur_y++;
            end else if (ch == CHAR_CR) begin
                cur_x = 0;
            end else if (ch == CHAR_BS) begin
                if (cur_x > 0) cur_x--;
            end
            if (cur_x >= nc) begin
                cur_x = 0;
                cur_y++;
            end
            if (cur_y >= nr) begin
                scroll_up(nc, nr);
                cur_y = nr - 1;
            end
        endfunction

        function void note_input(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] ch,
                                 logic [ROW_FIELD_W-1:0] r, logic [COL_FIELD_W-1:0] c);
            console_result_t res;
            int unsigned nc, nr;
            nc = used_cols();
            nr = used_rows();
            res.cell_char = '0;
            case (fn)
                FUNC_PUT: put_char(ch);
                FUNC_READ: begin
                    if (r < nr && c < nc) res.cell_char = screen[r*MAX_COLS_DEF + c];
                end
                FUNC_SET: begin
                    cur_x = (c < nc) ? c : nc - 1;
                    cur_y = (r < nr) ? r : nr - 1;
                end
                default: ;
            endcase
            res.cursor_col = cur_x[COL_FIELD_W-1:0];
            res.cursor_row = cur_y[ROW_FIELD_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned act_v);
            if (err_count < REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
            err_count++;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            console_result_t exp_r;
            if (pending_results.size() == 0) begin
                if (err_count < REPORT_CAP)
                    $display("%0t: unexpected output word: expected none, actual %h", $time, tdata);
                err_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (tdata[7:0] !== exp_r.cell_char)
                report("cell_char", exp_r.cell_char, tdata[7:0]);
            if (tdata[14:8] !== exp_r.cursor_col)
                report("cursor_col", exp_r.cursor_col, tdata[14:8]);
            if (tdata[20:15] !== exp_r.cursor_row)
                report("cursor_row", exp_r.cursor_row, tdata[20:15]);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [FUNC_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [COLUMNS_W-1:0] cfg_data;

    console_tracker sb = new();
    bit no_idle = 1'b0;
    bit no_stall = 1'b0;
    int unsigned cycle_count = 0;

    text_console_writer_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sample handshakes with pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8],
                              s_axis_tdata[20:14]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.apply_reg(cfg_index, cfg_data);
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int sender_gap();
        if (no_idle || $urandom_range(0, 99) < 45) return 0;
        return idle_len();
    endfunction

    // result side back-pressure
    initial begin
        int run_len, stall_len;
        forever begin
            run_len = $urandom_range(1, 30);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (!no_stall) begin
                stall_len = idle_len();
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_FIELD_W-1:0] r,
                             input logic [COL_FIELD_W-1:0] c);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {3'b000, c, r, ch};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding word to come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_geometry_reg(input logic idx, input logic [COLUMNS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly text with line control, plus reads, cursor moves and noise
    task automatic random_item();
        int k;
        logic [FUNC_W-1:0] fn;
        logic [CHAR_W-1:0] ch;
        logic [ROW_FIELD_W-1:0] r;
        logic [COL_FIELD_W-1:0] c;
        k  = $urandom_range(0, 99);
        fn = FUNC_PUT;
        ch = CHAR_W'($urandom_range(0, 255));
        r  = ROW_FIELD_W'($urandom_range(0, 63));
        c  = COL_FIELD_W'($urandom_range(0, 127));
        if (k < 55) ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        else if (k < 63) ch = CHAR_LF;
        else if (k < 66) ch = CHAR_CR;
        else if (k < 69) ch = CHAR_TAB;
        else if (k < 72) ch = CHAR_BS;
        else if (k < 77) ;
        else if (k < 95) begin
            fn = (k < 87) ? FUNC_READ : FUNC_SET;
            if ($urandom_range(0, 9) < 7) begin
                r = ROW_FIELD_W'($urandom_range(0, sb.used_rows() - 1));
                c = COL_FIELD_W'($urandom_range(0, sb.used_cols() - 1));
            end
        end else begin
            fn = FUNC_UNUSED;
        end
        send_word(fn, ch, r, c);
    endtask

    initial begin
        int unsigned sent, phase, n_items;
        logic [COLUMNS_W-1:0] cols_data, rows_data;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_PUT;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_COLUMNS;
        cfg_data      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset geometry (80 x 25)
        send_word(FUNC_READ, 8'h00, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_SPACE, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_TILDE, 6'd63, 7'd127);
        send_word(FUNC_PUT, 8'h1F, 6'd0, 7'd0);
        send_word(FUNC_PUT, 8'h7F, 6'd0, 7'd0);
        send_word(FUNC_PUT, 8'hFF, 6'd0, 7'd0);
        send_word(FUNC_PUT, 8'h00, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_TAB, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_BS, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_CR, 6'd0, 7'd0);
        send_word(FUNC_PUT, CHAR_BS, 6'd0, 7'd0);     // already at column 0
        send_word(FUNC_PUT, CHAR_LF, 6'd0, 7'd0);
        send_word(FUNC_READ, 8'hFF, 6'd0, 7'd1);
        send_word(FUNC_SET, 8'h00, 6'd0, 7'd78);
        send_word(FUNC_PUT, CHAR_TAB, 6'd0, 7'd0);    // tab past the last column wraps
        send_word(FUNC_SET, 8'h00, 6'd63, 7'd127);    // clamps to the last cell
        send_word(FUNC_PUT, 8'h41, 6'd0, 7'd0);       // wraps off the last row: scroll
        send_word(FUNC_READ, 8'h00, 6'd24, 7'd79);
        send_word(FUNC_READ, 8'h00, 6'd63, 7'd127);   // outside the area
        send_word(FUNC_READ, 8'h00, 6'd24, 7'd80);
        send_word(FUNC_UNUSED, 8'hFF, 6'd63, 7'd127);
        send_word(FUNC_SET, 8'h00, 6'd24, 7'd5);
        send_word(FUNC_PUT, CHAR_LF, 6'd0, 7'd0);     // newline on the last row
        send_word(FUNC_READ, 8'h00, 6'd23, 7'd0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            case (phase)
                0: begin cols_data = 8'd128; rows_data = 8'd64;  n_items = 40; end
                1: begin cols_data = 8'hFF;  rows_data = 8'hFF;  n_items = 30; end
                2: begin cols_data = 8'd0;   rows_data = 8'd0;   n_items = 60; end
                3: begin cols_data = 8'd1;   rows_data = 8'd1;   n_items = 60; end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        cols_data = COLUMNS_W'($urandom_range(17, 128));
                        rows_data = COLUMNS_W'($urandom_range(9, 64));
                        n_items = 40;
                    end else begin
                        cols_data = COLUMNS_W'($urandom_range(1, 16));
                        // bit 7 lies outside the rows register
                        rows_data = COLUMNS_W'($urandom_range(1, 8) |
                                               ($urandom_range(0, 1) << 7));
                        n_items = 100;
                    end
                end
            endcase
            if ($urandom_range(0, 1)) begin
                set_geometry_reg(REG_COLUMNS, cols_data);
                set_geometry_reg(REG_ROWS, rows_data);
            end else begin
                set_geometry_reg(REG_ROWS, rows_data);
                set_geometry_reg(REG_COLUMNS, cols_data);
            end
            no_idle  = ($urandom_range(0, 4) == 0);
            no_stall = ($urandom_range(0, 4) == 0);
            for (int unsigned i = 0; i < n_items; i++) begin
                if (phase % 3 == 1 && i == n_items / 2) drain();
                random_item();
                sent++;
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.err_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
